// ----- design/sll_pkg.sv -----
// Shared types and constants for the sequential list table.
package sll_pkg;

  localparam int OPCODE_W   = 2;
  localparam int POSITION_W = 4;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 5;
  localparam int CAP_W      = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_CHANGE = 2'd3
  } sll_op_t;

  typedef struct packed {
    sll_op_t                 opcode;
    logic [POSITION_W-1:0]   position;
    logic [VALUE_W-1:0]      value;
  } sll_in_t;

  typedef struct packed {
    logic                    ok;
    logic [VALUE_W-1:0]      read_value;
    logic [COUNT_W-1:0]      count;
  } sll_out_t;

  // Broadcast to every cell: which successful update happens this cycle.
  typedef struct packed {
    logic                    append;
    logic                    remove;
    logic                    change;
    logic [POSITION_W-1:0]   position;
  } sll_cmd_t;

endpackage

// ----- design/sequential_list_table.sv -----
// Top level of the sequential list table: control, cell chain and result register.
//
// The list takes one operation per input transfer on the in_valid/in_ready
// channel and returns exactly one result per operation on the
// out_valid/out_ready channel. An operation appends a word at the tail,
// deletes the entry at a position and closes the gap, reads an entry, or
// overwrites one. Each result carries a success flag, the word read by a
// successful get (zero otherwise) and the length of the list afterward.
// The operation is decoded combinationally; the cells update and the result is
// captured in the output register at the same clock edge.
// Throughput is one operation per cycle while the receiver keeps out_ready high;
// a delete moves every later live cell down by one in parallel.
// When the receiver stalls, the result register holds its transfer and
// in_ready stays low until that result is taken; a new operation is accepted
// in the same cycle the waiting result leaves.
// The capacity register is written by cfg_wr_en/cfg_wr_data at any edge.
// Synchronous reset empties the list, sets the capacity to 16 and drops any
// pending result. Cell contents are not cleared; only positions below the
// current length are ever read.
module sequential_list_table #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sll_pkg::sll_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sll_pkg::sll_out_t            out_data,
  input  logic                         cfg_wr_en,
  input  logic [sll_pkg::CAP_W-1:0]    cfg_wr_data
);
  import sll_pkg::*;

  // Fill counter width and a common width for comparing fill, capacity,
  // position and depth without losing bits.
  localparam int FW  = $clog2(DEPTH + 1);
  localparam int CW0 = (FW > CAP_W) ? FW : CAP_W;
  localparam int CW  = (CW0 > POSITION_W) ? CW0 : POSITION_W;
  // Only the first sixteen cells can be addressed by a position.
  localparam int RD_N = (DEPTH < (1 << POSITION_W)) ? DEPTH : (1 << POSITION_W);

  logic [CAP_W-1:0]       capacity;
  logic [FW-1:0]          fill;
  logic [FW-1:0]          fill_next;
  sll_out_t               result_next;

  logic                   accept;
  logic [CW-1:0]          fill_c;
  logic [CW-1:0]          cap_c;
  logic [CW-1:0]          pos_c;
  logic                   room;
  logic                   pos_ok;
  logic                   op_ok;
  sll_cmd_t               cmd;
  logic [63:0]            value_wide;
  logic [DATA_WIDTH-1:0]  wdata;
  logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_data;
  logic [63:0]            rd_wide;
  logic [CW-1:0]          fill_next_c;

  // A new operation enters when the result register is empty or emptying.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign fill_c = CW'(fill);
  assign cap_c  = CW'(capacity);
  assign pos_c  = CW'(in_data.position);

  // Append needs room under both the configured capacity and the cell count.
  assign room   = (fill_c < cap_c) && (fill_c < CW'(DEPTH));
  // Any position below the length is live, and therefore inside the chain.
  assign pos_ok = pos_c < fill_c;

  always_comb begin
    unique case (in_data.opcode)
      OP_APPEND: op_ok = room;
      OP_DELETE: op_ok = pos_ok;
      OP_GET:    op_ok = pos_ok;
      OP_CHANGE: op_ok = pos_ok;
      default:   op_ok = 1'b0;
    endcase
  end

  always_comb begin
    cmd.append   = accept && op_ok && (in_data.opcode == OP_APPEND);
    cmd.remove   = accept && op_ok && (in_data.opcode == OP_DELETE);
    cmd.change   = accept && op_ok && (in_data.opcode == OP_CHANGE);
    cmd.position = in_data.position;
  end

  // Store only the low DATA_WIDTH bits of the incoming word.
  assign value_wide = 64'(in_data.value);
  assign wdata      = value_wide[DATA_WIDTH-1:0];

  // The cell chain: each cell hands its word to the cell below it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] from_right;
    if (i == DEPTH - 1) begin : g_last
      assign from_right = '0;
    end else begin : g_mid
      assign from_right = cell_data[i + 1];
    end
    sll_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .fill     (fill),
      .wdata    (wdata),
      .neighbor (from_right),
      .data     (cell_data[i])
    );
  end

  // Read-out selects the addressed cell among those a position can reach.
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (pos_c == CW'(k)) begin
        rd_data = cell_data[k];
      end
    end
  end

  assign rd_wide = 64'(rd_data);

  always_comb begin
    fill_next = fill;
    if (cmd.append) begin
      fill_next = fill + FW'(1);
    end else if (cmd.remove) begin
      fill_next = fill - FW'(1);
    end
  end

  assign fill_next_c = CW'(fill_next);

  always_comb begin
    result_next.ok         = op_ok;
    result_next.read_value = (op_ok && (in_data.opcode == OP_GET)) ? rd_wide[VALUE_W-1:0]
                                                                   : '0;
    result_next.count      = fill_next_c[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      fill <= fill_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result_next;
    end
  end

endmodule

// ----- design/sll_cell.sv -----
// One storage cell of the list: loads a new word or takes its right neighbor's word.
module sll_cell #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                          clk,
  input  sll_pkg::sll_cmd_t             cmd,
  input  logic [$clog2(DEPTH+1)-1:0]    fill,
  input  logic [DATA_WIDTH-1:0]         wdata,
  input  logic [DATA_WIDTH-1:0]         neighbor,
  output logic [DATA_WIDTH-1:0]         data
);
  import sll_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > POSITION_W) ? FW : POSITION_W;
  localparam logic [CW-1:0] MY_IDX  = CW'(INDEX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(INDEX + 1);

  logic [CW-1:0] fill_c;
  logic [CW-1:0] pos_c;
  logic          load;
  logic          shift;

  assign fill_c = CW'(fill);
  assign pos_c  = CW'(cmd.position);

  // The tail cell takes an append; the addressed cell takes a change.
  assign load  = (cmd.append && (fill_c == MY_IDX)) ||
                 (cmd.change && (pos_c == MY_IDX));
  // On a delete, every cell from the hole up to below the last live one takes its neighbor's word.
  assign shift = cmd.remove && (MY_IDX >= pos_c) && (NEXT_IDX < fill_c);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= wdata;
    end else if (shift) begin
      data <= neighbor;
    end
  end

endmodule

// ----- bench/list_result_checker.sv -----
// Checker for the sequential list table: tracks the list, predicts each result and compares.
module list_result_checker #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  sll_pkg::sll_in_t            in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  sll_pkg::sll_out_t           out_data,
  input  logic                        cfg_wr_en,
  input  logic [sll_pkg::CAP_W-1:0]   cfg_wr_data,
  output int unsigned                 failure_count,
  output int unsigned                 pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import sll_pkg::*;

  logic [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
  logic [COUNT_W-1:0] shadow_fill;
  logic [CAP_W-1:0]   shadow_capacity;
  sll_out_t           expected_results [$];
  int unsigned        mismatches = 0;

  assign failure_count = mismatches;

  // Applies one operation to the shadow list and returns the result it should produce.
  function automatic sll_out_t apply_list_op(sll_in_t item);
    sll_out_t res;
    int       limit;
    res   = '0;
    limit = (shadow_capacity > LIST_DEPTH) ? LIST_DEPTH : int'(shadow_capacity);
    case (item.opcode)
      OP_APPEND: begin
        if (shadow_fill < limit) begin
          shadow_entries[shadow_fill] = item.value;
          shadow_fill = shadow_fill + 1'b1;
          res.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (item.position < shadow_fill) begin
          for (int i = item.position; i + 1 < shadow_fill; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_fill = shadow_fill - 1'b1;
          res.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (item.position < shadow_fill) begin
          res.read_value = shadow_entries[item.position];
          res.ok = 1'b1;
        end
      end
      default: begin
        if (item.position < shadow_fill) begin
          shadow_entries[item.position] = item.value;
          res.ok = 1'b1;
        end
      end
    endcase
    res.count = shadow_fill;
    return res;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    sll_out_t want;
    if (rst) begin
      shadow_fill = '0;
      shadow_capacity = CAP_RESET;
      expected_results.delete();
    end else begin
      // The result leaving now belongs to an earlier transfer, so check before pushing.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with nothing outstanding: ok=%0b read=%h count=%0d",
                                 out_data.ok, out_data.read_value, out_data.count));
        end else begin
          want = expected_results.pop_front();
          if (out_data.ok !== want.ok || out_data.read_value !== want.read_value ||
              out_data.count !== want.count) begin
            note_failure($sformatf("expected ok=%0b read=%h count=%0d, got ok=%0b read=%h count=%0d",
                                   want.ok, want.read_value, want.count,
                                   out_data.ok, out_data.read_value, out_data.count));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_list_op(in_data));
      end
      if (cfg_wr_en) begin
        shadow_capacity = cfg_wr_data;
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the sequential list table bench: clock, reset, stimulus and the final verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sll_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 300000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sll_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sll_out_t           out_data;
  logic               cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]   cfg_wr_data = '0;

  int unsigned        failure_count;
  int unsigned        pending_results;
  int unsigned        cycle_count = 0;
  // While set, neither the sender nor the receiver inserts any idle cycles.
  bit                 steady = 1'b0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  sequential_list_table #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  list_result_checker #(
    .LIST_DEPTH (LIST_DEPTH)
  ) list_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .failure_count   (failure_count),
    .pending_results (pending_results)
  );

  // The receiver stalls in random cycles, except during the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 14);
  end

  // Offers one operation and holds it until the transfer happens. A random idle gap may
  // come first; valid is only dropped in a cycle where no new item is raised.
  task automatic send_op(sll_op_t op, logic [POSITION_W-1:0] pos, logic [VALUE_W-1:0] val);
    sll_in_t item;
    item.opcode   = op;
    item.position = pos;
    item.value    = val;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // The capacity register is only written once the list is idle: no transfer is being
  // offered and every result has been taken. Each operation yields exactly one result,
  // so a short pause after the last one is enough.
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random operations in chunks of 50. Each chunk leans toward growing, holding or
  // shrinking the list, so the length wanders from empty to full and back.
  task automatic random_phase(logic [CAP_W-1:0] cap, int n_items);
    int                    append_pct;
    int                    pick;
    sll_op_t               op;
    logic [POSITION_W-1:0] pos;
    logic [VALUE_W-1:0]    val;
    set_capacity(cap);
    for (int k = 0; k < n_items; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       append_pct = 25;
          1:       append_pct = 50;
          default: append_pct = 75;
        endcase
      end
      if ($urandom_range(0, 99) < append_pct) begin
        op = OP_APPEND;
      end else begin
        pick = $urandom_range(0, 99);
        op = (pick < 40) ? OP_DELETE : (pick < 70) ? OP_GET : OP_CHANGE;
      end
      // Half the positions land near the head, where entries usually exist.
      pos = $urandom_range(0, 1) ? POSITION_W'($urandom_range(0, 15))
                                 : POSITION_W'($urandom_range(0, 5));
      case ($urandom_range(0, 19))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom();
      endcase
      send_op(op, pos, val);
    end
  endtask

  initial begin
    // Hold reset at the start; it is never asserted again.
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed part at full capacity: operations on an empty list, data extremes,
    // reads and changes inside and past the end, and deletes in the middle and at the tail.
    set_capacity(CAP_W'(16));
    send_op(OP_GET,    4'd0,  32'h0);
    send_op(OP_DELETE, 4'd0,  32'h0);
    send_op(OP_CHANGE, 4'd0,  32'hDEADBEEF);
    send_op(OP_APPEND, 4'd15, 32'h0000_0000);
    send_op(OP_APPEND, 4'd0,  32'hFFFF_FFFF);
    send_op(OP_APPEND, 4'd7,  32'h1234_5678);
    send_op(OP_APPEND, 4'd3,  32'h9ABC_DEF0);
    send_op(OP_APPEND, 4'd0,  32'h0F0F_0F0F);
    send_op(OP_GET,    4'd0,  32'h0);
    send_op(OP_GET,    4'd1,  32'h0);
    send_op(OP_GET,    4'd4,  32'h0);
    send_op(OP_GET,    4'd5,  32'h0);
    send_op(OP_GET,    4'd15, 32'hFFFF_FFFF);
    send_op(OP_CHANGE, 4'd1,  32'hA5A5_A5A5);
    send_op(OP_CHANGE, 4'd5,  32'h5A5A_5A5A);
    send_op(OP_DELETE, 4'd2,  32'h0);
    send_op(OP_DELETE, 4'd3,  32'h0);
    send_op(OP_DELETE, 4'd15, 32'h0);

    // Capacity drops below the current length: appends fail while the held entries
    // stay reachable, until deletes bring the length back under the limit.
    set_capacity(CAP_W'(2));
    send_op(OP_APPEND, 4'd0,  32'h1111_1111);
    send_op(OP_GET,    4'd2,  32'h0);
    send_op(OP_DELETE, 4'd0,  32'h0);
    send_op(OP_APPEND, 4'd0,  32'h2222_2222);
    send_op(OP_DELETE, 4'd1,  32'h0);
    send_op(OP_APPEND, 4'd0,  32'h3333_3333);

    // A capacity of zero refuses every append.
    set_capacity(CAP_W'(0));
    send_op(OP_APPEND, 4'd0,  32'h4444_4444);
    send_op(OP_GET,    4'd1,  32'h0);

    // Random part over several capacities, the largest encodable value among them.
    random_phase(CAP_W'(31), 300);
    steady = 1'b1;
    random_phase(CAP_W'(16), 250);
    steady = 1'b0;
    random_phase(CAP_W'(1), 100);
    random_phase(CAP_W'(0), 50);
    random_phase(CAP_W'(9), 200);
    random_phase(CAP_W'($urandom_range(0, 31)), 150);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    // Leave room for any stray result to show up before the verdict.
    repeat (8) @(posedge clk);
    if (failure_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
design/sll_pkg.sv
design/sll_cell.sv
design/sequential_list_table.sv
bench/list_result_checker.sv
bench/testbench.sv
